// File: hw/rtl/tcf_pkg.sv
// Package: shared types, constants and the angle step table for the tilt filter.
`default_nettype none
package tcf_pkg;
   localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
   localparam int unsigned ATAN_LEN = 24;
   localparam int unsigned TILT_W = 25;
   localparam int unsigned ANGLE_W = 24;
   localparam int unsigned DATA_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 2'd1;
   localparam logic [15:0] BLEND_RESET = 16'd64225;
   localparam logic [15:0] GAIN_RESET = 16'd32736;
   localparam logic signed [25:0] TILT_LIMIT = 26'sd11796480;
   localparam logic signed [25:0] RIGHT_ANGLE = 26'sd5898240;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_CORDIC,
      ST_MUL,
      ST_BLEND,
      ST_FUSE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] accel_x;
      logic [DATA_W-1:0] accel_y;
      logic [DATA_W-1:0] accel_z;
      logic [DATA_W-1:0] gyro_x;
      logic [DATA_W-1:0] gyro_y;
   } req_type;

   typedef struct packed {
      logic [TILT_W-1:0] tilt_x;
      logic [TILT_W-1:0] tilt_y;
      logic [ANGLE_W-1:0] accel_angle_x;
      logic [ANGLE_W-1:0] accel_angle_y;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [15:0] data;
   } csr_type;

   function automatic logic [21:0] atan_step(input logic [4:0] i);
      case (i)
         5'd0: atan_step = 22'd2949120;
         5'd1: atan_step = 22'd1740967;
         5'd2: atan_step = 22'd919879;
         5'd3: atan_step = 22'd466945;
         5'd4: atan_step = 22'd234379;
         5'd5: atan_step = 22'd117304;
         5'd6: atan_step = 22'd58666;
         5'd7: atan_step = 22'd29335;
         5'd8: atan_step = 22'd14668;
         5'd9: atan_step = 22'd7334;
         5'd10: atan_step = 22'd3667;
         5'd11: atan_step = 22'd1833;
         5'd12: atan_step = 22'd917;
         5'd13: atan_step = 22'd458;
         5'd14: atan_step = 22'd229;
         5'd15: atan_step = 22'd115;
         5'd16: atan_step = 22'd57;
         5'd17: atan_step = 22'd29;
         5'd18: atan_step = 22'd14;
         5'd19: atan_step = 22'd7;
         5'd20: atan_step = 22'd4;
         5'd21: atan_step = 22'd2;
         5'd22: atan_step = 22'd1;
         default: atan_step = 22'd0;
      endcase
   endfunction
endpackage
`default_nettype wire

// File: hw/rtl/tcf_if.sv
// Interfaces: valid/ready request, response and register write channels.
`default_nettype none
interface tcf_req_if;
   logic valid;
   logic ready;
   tcf_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tcf_rsp_if;
   logic valid;
   logic ready;
   tcf_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tcf_csr_if;
   logic valid;
   logic ready;
   tcf_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tilt_complementary_filter.sv
// Top level: complementary filter tilt estimator with serial root and CORDIC.
//
// Channels: req (accel x/y/z, gyro x/y), rsp (tilt x/y, accel angle x/y),
// csr (index 0 blend weight, index 1 gyro step gain; other indexes ignored).
// Both axes are worked one after the other through one shared datapath.
// Per axis: a radix-4 root (one result bit a cycle over a
// 64-bit operand, two operand bits shifted in), the CORDIC (one shift-add
// rotation a cycle, ANGLE_ITERATIONS rotations capped at ATAN_LEN), the
// gyro product, the blend products and the sum and clamp. The response
// is valid once both axes are done; an axis whose root operand is zero
// leaves the root at once and goes straight to the gyro product.
// One request is worked at a time; req ready is low from acceptance
// until the response has been taken. A stalled receiver holds the
// response register and the block. Reset restores register defaults
// and clears the previous tilt of both axes.
`default_nettype none
module tilt_complementary_filter #(
   parameter int unsigned ANGLE_ITERATIONS = tcf_pkg::ANGLE_ITERATIONS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tcf_req_if.sink req,
   tcf_rsp_if.source rsp,
   tcf_csr_if.sink csr
);
   localparam int unsigned ITER = (ANGLE_ITERATIONS < tcf_pkg::ATAN_LEN) ?
      ANGLE_ITERATIONS : tcf_pkg::ATAN_LEN;
   localparam logic [4:0] LAST_ITER = 5'(ITER - 1);

   tcf_pkg::state_type state_ff, state_in;
   logic [15:0] blend_ff, gain_ff;
   logic signed [24:0] prev_x_ff, prev_y_ff;
   tcf_pkg::req_type item_ff;
   tcf_pkg::rsp_type out_ff;
   logic axis_ff;
   logic [4:0] cnt_ff;
   logic [63:0] rad_ff;
   logic [31:0] rem_ff;
   logic [31:0] root_ff;
   logic signed [40:0] cx_ff, cy_ff;
   logic signed [25:0] z_ff;
   logic signed [31:0] gp_ff;
   logic signed [42:0] m1_ff, m2_ff;
   logic signed [25:0] ang_ff;

   logic signed [15:0] sa, sb, sc, sg;
   logic [31:0] sq;
   logic [33:0] rem_next;
   logic [34:0] trial;
   logic signed [40:0] dx, dy;
   logic signed [24:0] prev_sel;
   logic signed [43:0] mix;
   logic signed [27:0] sh;
   logic signed [25:0] tilt_c;

   always_comb begin
      sa = axis_ff ? $signed(item_ff.accel_y) : $signed(item_ff.accel_x);
      sb = axis_ff ? $signed(item_ff.accel_x) : $signed(item_ff.accel_y);
      sc = $signed(item_ff.accel_z);
      sg = axis_ff ? $signed(item_ff.gyro_y) : $signed(item_ff.gyro_x);
      prev_sel = axis_ff ? prev_y_ff : prev_x_ff;
      sq = 32'(32'(sb * sb)) + 32'(32'(sc * sc));
      rem_next = {rem_ff, rad_ff[63:62]};
      trial = {1'b0, rem_next} - {1'b0, root_ff, 2'b01};
      dx = cy_ff >>> cnt_ff;
      dy = cx_ff >>> cnt_ff;
      mix = 44'(m1_ff) + 44'(m2_ff);
      sh = 28'(mix >>> 16);
      if (sh > 28'(tcf_pkg::TILT_LIMIT)) tilt_c = tcf_pkg::TILT_LIMIT;
      else if (sh < -28'(tcf_pkg::TILT_LIMIT)) tilt_c = -tcf_pkg::TILT_LIMIT;
      else tilt_c = 26'(sh);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcf_pkg::ST_IDLE: if (req.valid) state_in = tcf_pkg::ST_ROOT;
         tcf_pkg::ST_ROOT: begin
            if (sq == 32'd0) state_in = tcf_pkg::ST_MUL;
            else if (cnt_ff == 5'd31) state_in = tcf_pkg::ST_CORDIC;
         end
         tcf_pkg::ST_CORDIC: if (cnt_ff == LAST_ITER) state_in = tcf_pkg::ST_MUL;
         tcf_pkg::ST_MUL: state_in = tcf_pkg::ST_BLEND;
         tcf_pkg::ST_BLEND: state_in = tcf_pkg::ST_FUSE;
         tcf_pkg::ST_FUSE: state_in = axis_ff ? tcf_pkg::ST_DONE : tcf_pkg::ST_ROOT;
         tcf_pkg::ST_DONE: if (rsp.ready) state_in = tcf_pkg::ST_IDLE;
         default: state_in = tcf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == tcf_pkg::ST_IDLE);
      rsp.valid = (state_ff == tcf_pkg::ST_DONE);
      rsp.data = out_ff;
      csr.ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcf_pkg::ST_IDLE;
         blend_ff <= tcf_pkg::BLEND_RESET;
         gain_ff <= tcf_pkg::GAIN_RESET;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         axis_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            if (csr.data.index == tcf_pkg::CSR_BLEND) blend_ff <= csr.data.data;
            else if (csr.data.index == tcf_pkg::CSR_GAIN) gain_ff <= csr.data.data;
         end
         case (state_ff)
            tcf_pkg::ST_IDLE: begin
               axis_ff <= 1'b0;
               cnt_ff <= '0;
            end
            tcf_pkg::ST_ROOT: cnt_ff <= (state_in == tcf_pkg::ST_ROOT) ? cnt_ff + 5'd1 : '0;
            tcf_pkg::ST_CORDIC: cnt_ff <= cnt_ff + 5'd1;
            tcf_pkg::ST_FUSE: begin
               cnt_ff <= '0;
               axis_ff <= 1'b1;
               if (axis_ff) prev_y_ff <= 25'(tilt_c);
               else prev_x_ff <= 25'(tilt_c);
            end
            default: cnt_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         tcf_pkg::ST_IDLE: begin
            item_ff <= req.data;
            rem_ff <= '0;
            root_ff <= '0;
            rad_ff <= '0;
         end
         tcf_pkg::ST_ROOT: begin
            if (cnt_ff == 5'd0) begin
               rad_ff <= {sq[29:0], 34'd0};
               rem_ff <= {30'd0, sq[31:30]} - ((sq[31:30] != 2'd0) ? 32'd1 : 32'd0);
               root_ff <= {31'd0, (sq[31:30] != 2'd0)};
            end else begin
               rad_ff <= {rad_ff[61:0], 2'b00};
               if (!trial[34]) begin
                  rem_ff <= trial[31:0];
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_next[31:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
            end
            if (sq == 32'd0)
               ang_ff <= (sa > 0) ? tcf_pkg::RIGHT_ANGLE :
                         (sa < 0) ? -tcf_pkg::RIGHT_ANGLE : '0;
            cx_ff <= '0;
            cy_ff <= 41'(sa) <<< 16;
            z_ff <= '0;
         end
         tcf_pkg::ST_CORDIC: begin
            if (cnt_ff == 5'd0) begin
               cx_ff <= 41'({1'b0, root_ff}) + (cy_ff[40] ? -cy_ff : cy_ff);
               cy_ff <= cy_ff[40] ? cy_ff + 41'({1'b0, root_ff}) :
                        cy_ff - 41'({1'b0, root_ff});
               z_ff <= cy_ff[40] ? -26'(tcf_pkg::atan_step(5'd0)) :
                       26'(tcf_pkg::atan_step(5'd0));
            end else if (!cy_ff[40]) begin
               cx_ff <= cx_ff + dx;
               cy_ff <= cy_ff - dy;
               z_ff <= z_ff + 26'(tcf_pkg::atan_step(cnt_ff));
            end else begin
               cx_ff <= cx_ff - dx;
               cy_ff <= cy_ff + dy;
               z_ff <= z_ff - 26'(tcf_pkg::atan_step(cnt_ff));
            end
            if (state_in == tcf_pkg::ST_MUL) ang_ff <= '0;
         end
         tcf_pkg::ST_MUL: begin
            if (z_ff != 26'sd0 || cx_ff != 41'sd0) begin
               if (z_ff > tcf_pkg::RIGHT_ANGLE) ang_ff <= tcf_pkg::RIGHT_ANGLE;
               else if (z_ff < -tcf_pkg::RIGHT_ANGLE) ang_ff <= -tcf_pkg::RIGHT_ANGLE;
               else ang_ff <= z_ff;
            end
            gp_ff <= 32'(sg * $signed({1'b0, gain_ff}));
         end
         tcf_pkg::ST_FUSE: ;
         default: ;
      endcase
      if (state_ff == tcf_pkg::ST_FUSE && axis_ff) out_ff.accel_angle_y <= 24'(ang_ff);
      if (state_ff == tcf_pkg::ST_FUSE && !axis_ff) out_ff.accel_angle_x <= 24'(ang_ff);
      if (state_ff == tcf_pkg::ST_FUSE && axis_ff) out_ff.tilt_y <= 25'(tilt_c);
      if (state_ff == tcf_pkg::ST_FUSE && !axis_ff) out_ff.tilt_x <= 25'(tilt_c);
   end

   // blend products, registered in the cycle after the gyro product
   logic signed [26:0] sum_g;
   always_comb begin
      sum_g = 27'(prev_sel) + 27'(gp_ff >>> 16);
   end

   logic signed [42:0] p1, p2;
   always_comb begin
      p1 = 43'(sum_g * $signed({1'b0, blend_ff}));
      p2 = 43'(ang_ff * $signed(18'(18'sd65536 - $signed({2'b0, blend_ff}))));
   end

   always_ff @(posedge clock) begin
      if (state_ff == tcf_pkg::ST_BLEND) begin
         m1_ff <= p1;
         m2_ff <= p2;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request accepted while response pending");
   assert property (@(posedge clock) disable iff (reset)
      ($signed(prev_x_ff) <= 25'sd11796480) && ($signed(prev_x_ff) >= -25'sd11796480))
      else $error("previous tilt out of range");
endmodule
`default_nettype wire

// File: tb/sv/tilt_complementary_filter_test.sv
// Testbench: checks the tilt filter against an in-bench fixed-point predictor.
`default_nettype none
module tilt_complementary_filter_test;
   localparam logic [tcf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcf_req_if req_ch ();
   tcf_rsp_if rsp_ch ();
   tcf_csr_if csr_ch ();

   tilt_complementary_filter i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr(csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [15:0] weight_q;
   logic [15:0] gain_q;
   logic signed [63:0] prev_tilt_x;
   logic signed [63:0] prev_tilt_y;
   tcf_pkg::rsp_type pending_tilts[$];
   int unsigned error_count = 0;
   int unsigned request_count = 0;
   int unsigned response_count = 0;
   int unsigned rsp_wait = 0;

   function automatic logic [63:0] isqrt64(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic signed [63:0] tilt_angle(input logic signed [15:0] a,
                                                     input logic signed [15:0] b,
                                                     input logic signed [15:0] c);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] step;
      logic [63:0] sq;
      sq = b * b + c * c;
      z = 0;
      if (sq == 0) return (a > 0) ? 64'sd5898240 : (a < 0) ? -64'sd5898240 : 64'sd0;
      x = isqrt64(sq << 32);
      y = 64'(a) * 65536;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         case (i)
            0: step = 2949120;   1: step = 1740967;   2: step = 919879;
            3: step = 466945;    4: step = 234379;    5: step = 117304;
            6: step = 58666;     7: step = 29335;     8: step = 14668;
            9: step = 7334;      10: step = 3667;     11: step = 1833;
            12: step = 917;      13: step = 458;      14: step = 229;
            default: step = 115;
         endcase
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + step;
         end else begin
            x = x - dx; y = y + dy; z = z - step;
         end
      end
      return clip(z, 64'sd5898240);
   endfunction

   function automatic logic signed [63:0] blend_tilt(input logic signed [63:0] prev,
                                                     input logic signed [15:0] rate,
                                                     input logic signed [63:0] acc);
      logic signed [63:0] w;
      logic signed [63:0] sum;
      logic signed [63:0] mix;
      w = {48'd0, weight_q};
      sum = prev + ((64'(rate) * $signed({48'd0, gain_q})) >>> 16);
      mix = w * sum + (64'sd65536 - w) * acc;
      return clip(mix >>> 16, 64'sd11796480);
   endfunction

   task automatic predict_tilt(input tcf_pkg::req_type r);
      tcf_pkg::rsp_type e;
      logic signed [63:0] ax;
      logic signed [63:0] ay;
      logic signed [63:0] tx;
      logic signed [63:0] ty;
      ax = tilt_angle(r.accel_x, r.accel_y, r.accel_z);
      ay = tilt_angle(r.accel_y, r.accel_x, r.accel_z);
      tx = blend_tilt(prev_tilt_x, r.gyro_x, ax);
      ty = blend_tilt(prev_tilt_y, r.gyro_y, ay);
      prev_tilt_x = tx;
      prev_tilt_y = ty;
      e.tilt_x = tx[24:0];
      e.tilt_y = ty[24:0];
      e.accel_angle_x = ax[23:0];
      e.accel_angle_y = ay[23:0];
      pending_tilts.push_back(e);
   endtask

   task automatic send_sample(input tcf_pkg::req_type r, input bit gaps = 1'b1);
      int gap;
      gap = gaps ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tilt(r);
      request_count++;
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (pending_tilts.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tcf_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= '{index: idx, data: val};
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == tcf_pkg::CSR_BLEND) weight_q = val;
      else if (idx == tcf_pkg::CSR_GAIN) gain_q = val;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic tcf_pkg::req_type rand_sample();
      tcf_pkg::req_type r;
      r = 80'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 7))
         0: r.accel_y = '0;
         1: begin r.accel_y = '0; r.accel_z = '0; end
         2: r.accel_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         3: r.gyro_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: ;
      endcase
      return r;
   endfunction

   task automatic test_directed;
      logic [15:0] edges[5];
      edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
      send_sample('0);
      send_sample('{accel_x: 16'd100, default: 16'd0});
      send_sample('{accel_x: 16'hff00, default: 16'd0});
      send_sample('{accel_y: 16'h7fff, default: 16'd0});
      send_sample('{accel_y: 16'h8000, default: 16'd0});
      for (int i = 0; i < 5; i++)
         send_sample('{accel_x: edges[i], accel_y: edges[(i + 1) % 5],
                       accel_z: edges[(i + 2) % 5], gyro_x: edges[(i + 3) % 5],
                       gyro_y: edges[(i + 4) % 5]});
      for (int i = 0; i < 8; i++)
         send_sample('{accel_x: 16'h7fff, accel_y: 16'h7fff, accel_z: 16'h0,
                       gyro_x: 16'h7fff, gyro_y: 16'h7fff});
   endtask

   task automatic test_weights;
      drain();
      write_reg(tcf_pkg::CSR_BLEND, 16'd0);
      write_reg(tcf_pkg::CSR_GAIN, 16'hffff);
      write_reg(CSR_UNUSED, 16'h1234);
      repeat (6) send_sample(rand_sample());
      drain();
      write_reg(tcf_pkg::CSR_BLEND, 16'hffff);
      for (int i = 0; i < 12; i++)
         send_sample('{accel_x: 16'h1000, accel_y: 16'h0, accel_z: 16'h4000,
                       gyro_x: (i < 8) ? 16'h8000 : 16'h7fff, gyro_y: 16'h7fff});
   endtask

   task automatic test_random(input int n);
      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(tcf_pkg::CSR_BLEND, 16'($urandom));
         write_reg(tcf_pkg::CSR_GAIN, 16'($urandom));
         for (int i = 0; i < n / 4; i++) send_sample(rand_sample(), (i % 150) > 40);
      end
      drain();
      write_reg(tcf_pkg::CSR_BLEND, tcf_pkg::BLEND_RESET);
      write_reg(tcf_pkg::CSR_GAIN, tcf_pkg::GAIN_RESET);
      for (int i = 0; i < 200; i++) send_sample(rand_sample());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = $urandom_range(0, 14);
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         response_count++;
         if (pending_tilts.size() == 0) begin
            $display("%0t: response with nothing expected, actual %h", $realtime, rsp_ch.data);
            error_count++;
         end else begin
            tcf_pkg::rsp_type e;
            e = pending_tilts.pop_front();
            if (rsp_ch.data !== e) begin
               $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h", $realtime,
                        e.tilt_x, e.tilt_y, e.accel_angle_x, e.accel_angle_y,
                        rsp_ch.data.tilt_x, rsp_ch.data.tilt_y,
                        rsp_ch.data.accel_angle_x, rsp_ch.data.accel_angle_y);
               error_count++;
            end
         end
         rsp_wait = $urandom_range(0, 14);
      end else if (rsp_ch.valid && rsp_wait != 0) begin
         rsp_wait--;
      end
      rsp_ch.ready <= !reset && (rsp_wait == 0);
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      weight_q = tcf_pkg::BLEND_RESET;
      gain_q = tcf_pkg::GAIN_RESET;
      prev_tilt_x = 0;
      prev_tilt_y = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_weights();
      test_random(1700);
      drain();
      if (pending_tilts.size() != 0) error_count++;
      $display("covered %0d requests, %0d responses, edge fields, weight extremes", request_count,
               response_count);
      if (error_count == 0) begin
         $display("tilt_complementary_filter_test: done, clean");
      end else begin
         $display("tilt_complementary_filter_test: done, errors");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tilt_complementary_filter_test: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
